// ===== rtl/npvl_pkg.sv =====
// shared constants, types and result codes for the nearest point lookup
package npvl_pkg;

    localparam int MAX_POINTS    = 256;
    localparam int COORD_BITS    = 24;
    localparam int IDX_BITS      = $clog2(MAX_POINTS);
    localparam int CNT_BITS      = $clog2(MAX_POINTS + 1);
    localparam int OUT_IDX_BITS  = 8;
    localparam int DIST_BITS     = 50;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * DIFF_BITS;
    localparam int CMP_BITS      = (SQ_BITS > DIST_BITS) ? SQ_BITS : DIST_BITS;
    localparam int WORD_BITS     = 2 * COORD_BITS + 1;
    localparam int IN_FLD_BITS   = 2 * COORD_BITS + 1;
    localparam int IN_DATA_BITS  = ((IN_FLD_BITS + 7) / 8) * 8;
    localparam int RES_BITS      = 3 + OUT_IDX_BITS + 2 * COORD_BITS;
    localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

    localparam logic [DIST_BITS-1:0] CUTOFF_RESET = 50'd2560000000000;

    localparam logic [1:0] RES_INSERT = 2'd0;
    localparam logic [1:0] RES_FULL   = 2'd1;
    localparam logic [1:0] RES_QUERY  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic                load_in;
        logic                wr_en;
        logic                rd_en;
        logic [IDX_BITS-1:0] addr;
        logic                out_load;
        logic [1:0]          res_kind;
    } npvl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } npvl_stat_t;

    typedef struct packed {
        logic                         table_full;
        logic                         visible_out;
        logic signed [COORD_BITS-1:0] near_y;
        logic signed [COORD_BITS-1:0] near_x;
        logic [OUT_IDX_BITS-1:0]      entry_index;
        logic                         found;
    } npvl_res_t;

    function automatic logic [OUT_IDX_BITS-1:0] out_idx(input logic [IDX_BITS-1:0] i);
        logic [IDX_BITS+OUT_IDX_BITS-1:0] w;
        w = {{OUT_IDX_BITS{1'b0}}, i};
        return w[OUT_IDX_BITS-1:0];
    endfunction

endpackage

// ===== rtl/nearest_point_visibility_lookup.sv =====
// top level of the nearest point lookup with visibility flags
//
//  channel  direction  signals                         item
//  s_       in         s_tvalid s_tready s_tdata s_tuser  insert or query
//  m_       out        m_tvalid m_tready m_tdata          one result per item
//  cfg_     in         cfg_valid cfg_ready cfg_data       cutoff distance squared
//
// insert: ST_WRITE then ST_DONE; a dropped insert or empty-table query goes to ST_DONE
// query: one memory read per stored entry plus a
// three-stage diff / square / compare pipeline
// one item in flight; the next item is taken once the result sits in the output register
// reset clears entry count and handshake state and resets the cutoff; stored points stay
module nearest_point_visibility_lookup (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [npvl_pkg::IN_DATA_BITS-1:0]    s_tdata,   // point_x, point_y, visible_in
    input  logic                                 s_tuser,   // mode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // found, entry_index, near_x, near_y, visible_out, table_full
    output logic [npvl_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [npvl_pkg::DIST_BITS-1:0]       cfg_data
);
    import npvl_pkg::*;

    npvl_cmd_t  cmd;
    npvl_stat_t stat;
    npvl_res_t  res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_DATA_BITS'(res);

    npvl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    npvl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .point_x    (s_tdata[COORD_BITS-1:0]),
        .point_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .visible_in (s_tdata[2*COORD_BITS]),
        .res        (res)
    );

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending item");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.table_full && res.found))
        else $error("result both full and found");

    a_scan_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("memory read and write in one cycle");
`endif

endmodule

// ===== rtl/npvl_ctrl.sv =====
// controller state machine: entry count, scan sequencing and output handshake
module npvl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                mode,
    output logic                m_tvalid,
    input  logic                m_tready,
    output npvl_pkg::npvl_cmd_t cmd,
    input  npvl_pkg::npvl_stat_t stat
);
    import npvl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] scan_reg, scan_next;
    logic [1:0]          kind_reg, kind_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                accept;
    logic [CNT_BITS-1:0] scan_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign scan_inc = scan_reg + 1'b1;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        scan_next     = scan_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.load_in   = accept;
        cmd.res_kind  = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_next = '0;
                    if (mode == MODE_QUERY) begin
                        kind_next  = RES_QUERY;
                        state_next = (cnt_reg == '0) ? ST_DONE : ST_SCAN;
                    end else if (cnt_reg == CNT_BITS'(MAX_POINTS)) begin
                        kind_next  = RES_FULL;
                        state_next = ST_DONE;
                    end else begin
                        kind_next  = RES_INSERT;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.addr   = cnt_reg[IDX_BITS-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                cmd.addr  = scan_reg[IDX_BITS-1:0];
                scan_next = scan_inc;
                if (scan_inc == cnt_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            scan_reg     <= '0;
            kind_reg     <= RES_INSERT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            scan_reg     <= scan_next;
            kind_reg     <= kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/npvl_dp.sv =====
// datapath: point memory, distance pipeline, running minimum and result register
module npvl_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  npvl_pkg::npvl_cmd_t                    cmd,
    output npvl_pkg::npvl_stat_t                   stat,
    input  logic                                   cfg_we,
    input  logic [npvl_pkg::DIST_BITS-1:0]         cfg_data,
    input  logic signed [npvl_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [npvl_pkg::COORD_BITS-1:0] point_y,
    input  logic                                   visible_in,
    output npvl_pkg::npvl_res_t                    res
);
    import npvl_pkg::*;

    logic [WORD_BITS-1:0] mem [MAX_POINTS];

    logic [DIST_BITS-1:0]         cutoff_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                         qv_reg;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [WORD_BITS-1:0]  word1_reg, word2_reg, word3_reg;
    logic [IDX_BITS-1:0]   idx1_reg, idx2_reg, idx3_reg;
    logic signed [DIFF_BITS-1:0] dx2_reg, dy2_reg, dx_next, dy_next;
    logic signed [SQ_BITS-1:0]   sqx_next, sqy_next;
    logic [SQ_BITS-1:0]    sqx3_reg, sqy3_reg, sum;

    logic [CMP_BITS-1:0]   best_reg;
    logic                  hit_reg;
    logic [IDX_BITS-1:0]   win_idx_reg, ins_idx_reg;
    logic [WORD_BITS-1:0]  win_word_reg;
    npvl_res_t             res_reg, res_next;

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign res            = res_reg;

    // word layout: vis, y, x
    always_comb begin
        dx_next  = DIFF_BITS'($signed(word1_reg[COORD_BITS-1:0])) - DIFF_BITS'(qx_reg);
        dy_next  = DIFF_BITS'($signed(word1_reg[2*COORD_BITS-1:COORD_BITS]))
                 - DIFF_BITS'(qy_reg);
        sqx_next = dx2_reg * dx2_reg;
        sqy_next = dy2_reg * dy2_reg;
        sum      = sqx3_reg + sqy3_reg;
    end

    always_comb begin
        res_next = '0;
        unique case (cmd.res_kind)
            RES_INSERT: res_next.entry_index = out_idx(ins_idx_reg);
            RES_FULL:   res_next.table_full  = 1'b1;
            RES_QUERY: begin
                if (hit_reg) begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = out_idx(win_idx_reg);
                    res_next.near_x      = win_word_reg[COORD_BITS-1:0];
                    res_next.near_y      = win_word_reg[2*COORD_BITS-1:COORD_BITS];
                    res_next.visible_out = win_word_reg[WORD_BITS-1];
                end
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= {qv_reg, qy_reg, qx_reg};
        end
        if (cmd.rd_en) begin
            word1_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                cutoff_reg <= cfg_data;
            end
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            qx_reg   <= point_x;
            qy_reg   <= point_y;
            qv_reg   <= visible_in;
            best_reg <= CMP_BITS'(cutoff_reg);
            hit_reg  <= 1'b0;
        end else if (v3_reg && (CMP_BITS'(sum) < best_reg)) begin
            best_reg     <= CMP_BITS'(sum);
            hit_reg      <= 1'b1;
            win_idx_reg  <= idx3_reg;
            win_word_reg <= word3_reg;
        end
        if (cmd.wr_en) begin
            ins_idx_reg <= cmd.addr;
        end
        idx1_reg  <= cmd.addr;
        idx2_reg  <= idx1_reg;
        word2_reg <= word1_reg;
        dx2_reg   <= dx_next;
        dy2_reg   <= dy_next;
        idx3_reg  <= idx2_reg;
        word3_reg <= word2_reg;
        sqx3_reg  <= $unsigned(sqx_next);
        sqy3_reg  <= $unsigned(sqy_next);
        if (cmd.out_load) begin
            res_reg <= res_next;
        end
    end

endmodule
